// ----- src/tks_pkg.sv -----
// Shared constants and types for the streaming top-k selector.
package tks_pkg;

  // Default sizing handed to the top level
  localparam int unsigned MaxKDef     = 8;
  localparam int unsigned MaxItemsDef = 4096;

  // Fixed field widths
  localparam int unsigned ScoreW = 32;
  localparam int unsigned CfgW   = 4;

  // Reset value of the k register
  localparam logic [CfgW-1:0] KReset = 4'd5;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic last;    // that beat closes the vector
    logic shift;   // result beat taken, advance drain row
  } cell_ctrl_t;

endpackage

// ----- src/tks_in_if.sv -----
// Input stream channel: one score per beat with end-of-vector mark.
interface tks_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [tks_pkg::ScoreW-1:0] score;
  logic                             last_item;

  modport source (output valid, output score, output last_item, input ready);
  modport sink   (input valid, input score, input last_item, output ready);
endinterface

// ----- src/tks_out_if.sv -----
// Result stream channel: one ranked entry per beat.
interface tks_out_if #(
  parameter int unsigned RankW = 3,
  parameter int unsigned IdxW  = 12
);
  logic                             valid;
  logic                             ready;
  logic [RankW-1:0]                 rank;
  logic [IdxW-1:0]                  class_index;
  logic signed [tks_pkg::ScoreW-1:0] best_score;
  logic                             last_result;

  modport source (output valid, output rank, output class_index, output best_score,
                  output last_result, input ready);
  modport sink   (input valid, input rank, input class_index, input best_score,
                  input last_result, output ready);
endinterface

// ----- src/tks_cell.sv -----
// One slot of the sorted list plus one slot of the result drain row.
module tks_cell #(
  parameter int unsigned IdxW = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tks_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [tks_pkg::ScoreW-1:0] new_score_i,
  input  logic [IdxW-1:0]                  new_index_i,
  // neighbor toward rank 0
  input  logic                             prev_beats_i,
  input  logic                             prev_valid_i,
  input  logic signed [tks_pkg::ScoreW-1:0] prev_score_i,
  input  logic [IdxW-1:0]                  prev_index_i,
  // neighbor toward the tail, drain row
  input  logic signed [tks_pkg::ScoreW-1:0] next_drain_score_i,
  input  logic [IdxW-1:0]                  next_drain_index_i,
  output logic                             beats_o,
  output logic                             valid_o,
  output logic signed [tks_pkg::ScoreW-1:0] score_o,
  output logic [IdxW-1:0]                  index_o,
  output logic signed [tks_pkg::ScoreW-1:0] drain_score_o,
  output logic [IdxW-1:0]                  drain_index_o
);

  logic                             valid_q, valid_d;
  logic signed [tks_pkg::ScoreW-1:0] score_q, score_d;
  logic [IdxW-1:0]                  index_q, index_d;
  logic signed [tks_pkg::ScoreW-1:0] dscore_q;
  logic [IdxW-1:0]                  dindex_q;

  // New score outranks this slot; ties stay behind the kept entry
  assign beats_o = !valid_q || (new_score_i > score_q);

  // Take the neighbor's entry, take the new entry, or hold
  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    index_d = index_q;
    if (prev_beats_i) begin
      valid_d = prev_valid_i;
      score_d = prev_score_i;
      index_d = prev_index_i;
    end else if (beats_o) begin
      valid_d = 1'b1;
      score_d = new_score_i;
      index_d = new_index_i;
    end
  end

  // Slot occupancy: drop everything once a vector closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      valid_q <= ctrl_i.last ? 1'b0 : valid_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      score_q <= score_d;
      index_q <= index_d;
    end
  end

  // Drain row: load the final list, then advance toward rank 0
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && ctrl_i.last) begin
      dscore_q <= score_d;
      dindex_q <= index_d;
    end else if (ctrl_i.shift) begin
      dscore_q <= next_drain_score_i;
      dindex_q <= next_drain_index_i;
    end
  end

  assign valid_o       = valid_q;
  assign score_o       = score_q;
  assign index_o       = index_q;
  assign drain_score_o = dscore_q;
  assign drain_index_o = dindex_q;

endmodule

// ----- src/top_k_select_core.sv -----
// Streaming top-k selector: a chain of compare-insert cells and a drain row.
//
// Usage: scores enter on in_i, one per beat, numbered from 0 in arrival
// order; last_item marks the final score of a vector. A row of MAX_K cells
// keeps the highest scores in descending order, ties behind earlier
// positions. Every cell compares against the incoming score in parallel,
// so one score is taken every cycle that in_i.ready is high.
// When the last score of a vector is taken, the final list is copied into
// the drain row and the cells clear at once for the next vector. The
// results appear on out_o from the next cycle: min(k, scores seen) beats,
// rank 0 first, last_result on the final one. k_count 0 counts as 1 and
// values above MAX_K count as MAX_K; write it only while the block is idle.
// A stalled out_o holds the current result; non-last scores of the next
// vector are still taken meanwhile. A last score waits (ready low) until
// the drain row has emptied, that is until every reported rank is taken.
// Reset clears the list, the position counter and the drain count and sets
// k_count to 5. Positions saturate at MAX_ITEMS-1.
module top_k_select_core #(
  parameter int unsigned MAX_K     = tks_pkg::MaxKDef,
  parameter int unsigned MAX_ITEMS = tks_pkg::MaxItemsDef,
  parameter int unsigned RankW     = (MAX_K > 1) ? $clog2(MAX_K) : 1,
  parameter int unsigned IdxW      = $clog2(MAX_ITEMS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      k_count_we_i,
  input  logic [tks_pkg::CfgW-1:0]  k_count_i,
  tks_in_if.sink                    in_i,
  tks_out_if.source                 out_o
);

  localparam int unsigned CntW = $clog2(MAX_K + 1);
  localparam int unsigned KW   = (CntW > tks_pkg::CfgW) ? CntW : tks_pkg::CfgW;

  logic [tks_pkg::CfgW-1:0] k_q;
  logic [IdxW-1:0]          pos_q;
  logic [CntW-1:0]          kept_q, kept_d;
  logic [CntW-1:0]          left_q;
  logic [CntW-1:0]          rank_q;
  logic [KW-1:0]            k_eff;
  logic [KW-1:0]            n_wide;
  logic                     busy;
  logic                     in_fire, out_fire;
  tks_pkg::cell_ctrl_t      ctrl;

  logic                             beats_w  [MAX_K];
  logic                             valid_w  [MAX_K];
  logic signed [tks_pkg::ScoreW-1:0] score_w  [MAX_K];
  logic [IdxW-1:0]                  index_w  [MAX_K];
  logic signed [tks_pkg::ScoreW-1:0] dscore_w [MAX_K];
  logic [IdxW-1:0]                  dindex_w [MAX_K];

  // Handshakes: a closing score waits for the drain row to empty
  assign busy        = (left_q != '0);
  assign in_i.ready  = !(in_i.last_item && busy);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign ctrl.accept = in_fire;
  assign ctrl.last   = in_i.last_item;
  assign ctrl.shift  = out_fire;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= tks_pkg::KReset;
    end else if (k_count_we_i) begin
      k_q <= k_count_i;
    end
  end

  // Clamp k and count the results of the closing vector
  always_comb begin
    kept_d = (kept_q == CntW'(MAX_K)) ? kept_q : kept_q + 1'b1;
    if (k_q == '0) begin
      k_eff = KW'(1);
    end else if (KW'(k_q) > KW'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(k_q);
    end
    n_wide = (KW'(kept_d) < k_eff) ? KW'(kept_d) : k_eff;
  end

  // Position counter and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kept_q <= '0;
    end else if (in_fire) begin
      if (in_i.last_item) begin
        pos_q  <= '0;
        kept_q <= '0;
      end else begin
        kept_q <= kept_d;
        if (pos_q != IdxW'(MAX_ITEMS - 1)) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // Drain bookkeeping: results left and current rank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      rank_q <= '0;
    end else if (in_fire && in_i.last_item) begin
      left_q <= CntW'(n_wide);
      rank_q <= '0;
    end else if (out_fire) begin
      left_q <= left_q - 1'b1;
      rank_q <= rank_q + 1'b1;
    end
  end

  // Cell chain
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                             prev_beats;
    logic                             prev_valid;
    logic signed [tks_pkg::ScoreW-1:0] prev_score;
    logic [IdxW-1:0]                  prev_index;
    logic signed [tks_pkg::ScoreW-1:0] nxt_dscore;
    logic [IdxW-1:0]                  nxt_dindex;

    if (i == 0) begin : g_head
      assign prev_beats = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_score = '0;
      assign prev_index = '0;
    end else begin : g_body
      assign prev_beats = beats_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_score = score_w[i-1];
      assign prev_index = index_w[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign nxt_dscore = dscore_w[i];
      assign nxt_dindex = dindex_w[i];
    end else begin : g_mid
      assign nxt_dscore = dscore_w[i+1];
      assign nxt_dindex = dindex_w[i+1];
    end

    tks_cell #(
      .IdxW (IdxW)
    ) u_cell (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .ctrl_i             (ctrl),
      .new_score_i        (in_i.score),
      .new_index_i        (pos_q),
      .prev_beats_i       (prev_beats),
      .prev_valid_i       (prev_valid),
      .prev_score_i       (prev_score),
      .prev_index_i       (prev_index),
      .next_drain_score_i (nxt_dscore),
      .next_drain_index_i (nxt_dindex),
      .beats_o            (beats_w[i]),
      .valid_o            (valid_w[i]),
      .score_o            (score_w[i]),
      .index_o            (index_w[i]),
      .drain_score_o      (dscore_w[i]),
      .drain_index_o      (dindex_w[i])
    );
  end

  // Result beat from the head of the drain row
  assign out_o.valid       = busy;
  assign out_o.rank        = RankW'(rank_q);
  assign out_o.class_index = dindex_w[0];
  assign out_o.best_score  = dscore_w[0];
  assign out_o.last_result = (left_q == CntW'(1));

endmodule

// ----- tb/sv/tb_tks_rank_check.sv -----
// Channel monitor for the top-k selector: predicts each ranked list and compares result beats.
module tb_tks_rank_check
  import tks_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            k_count_we_i,
  input  logic [CfgW-1:0] k_count_i,
  tks_in_if               in_i,
  tks_out_if              out_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     vector_count_o,
  output int unsigned     result_count_o,
  output logic            sat_seen_o
);

  localparam int KeptMax = MaxKDef;
  localparam int PosMax  = MaxItemsDef - 1;
  localparam int IdxW    = $clog2(MaxItemsDef);
  localparam int RankW   = $clog2(MaxKDef);

  typedef struct packed {
    logic [RankW-1:0]         rank;
    logic [IdxW-1:0]          class_index;
    logic signed [ScoreW-1:0] best_score;
    logic                     last_result;
  } ranked_beat_t;

  // Predicted selector state
  logic signed [ScoreW-1:0] kept_score [KeptMax];
  logic [IdxW-1:0]          kept_index [KeptMax];
  int                       kept_n = 0;
  int                       next_pos = 0;
  logic [CfgW-1:0]          k_reg = KReset;
  ranked_beat_t             expected_ranks [$];

  int unsigned mismatches = 0;
  int unsigned vectors = 0;
  int unsigned results = 0;
  logic        sat_seen = 1'b0;

  assign fail_count_o   = mismatches;
  assign vector_count_o = vectors;
  assign result_count_o = results;
  assign sat_seen_o     = sat_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : rank_model
    ranked_beat_t want;
    int           slot;
    int           keff;
    int           n;

    if (!rst_ni) begin
      kept_n   = 0;
      next_pos = 0;
      k_reg    = KReset;
      expected_ranks.delete();
      pending_o <= 0;
    end else begin
      // Compare a result beat against the oldest predicted rank
      if (out_i.valid && out_i.ready) begin
        results++;
        if (out_i.class_index == IdxW'(PosMax)) sat_seen = 1'b1;
        if (expected_ranks.size() == 0) begin
          report_mismatch("result beat with no ranked list owed",
                          out_i.class_index, 0);
        end else begin
          want = expected_ranks.pop_front();
          if (out_i.rank != want.rank)
            report_mismatch("rank", out_i.rank, want.rank);
          if (out_i.class_index != want.class_index)
            report_mismatch("class_index", out_i.class_index, want.class_index);
          if (out_i.best_score != want.best_score)
            report_mismatch("best_score", out_i.best_score, want.best_score);
          if (out_i.last_result != want.last_result)
            report_mismatch("last_result", out_i.last_result, want.last_result);
        end
      end

      // Insert the score beat behind every kept score that is not lower
      if (in_i.valid && in_i.ready) begin
        slot = 0;
        while (slot < kept_n && kept_score[slot] >= in_i.score) slot++;
        if (slot < KeptMax) begin
          for (int j = (kept_n < KeptMax) ? kept_n : KeptMax - 1; j > slot; j--) begin
            kept_score[j] = kept_score[j-1];
            kept_index[j] = kept_index[j-1];
          end
          kept_score[slot] = in_i.score;
          kept_index[slot] = IdxW'(next_pos);
          if (kept_n < KeptMax) kept_n++;
        end
        // Saturate the position at the top of the index range
        if (next_pos < PosMax) next_pos++;

        // Close the vector: queue min(k, kept) ranks, then clear
        if (in_i.last_item) begin
          keff = (k_reg == 0) ? 1 : ((int'(k_reg) > KeptMax) ? KeptMax : int'(k_reg));
          n = (kept_n < keff) ? kept_n : keff;
          for (int r = 0; r < n; r++) begin
            want.rank        = RankW'(r);
            want.class_index = kept_index[r];
            want.best_score  = kept_score[r];
            want.last_result = (r == n - 1);
            expected_ranks.push_back(want);
          end
          kept_n   = 0;
          next_pos = 0;
          vectors++;
        end
      end

      if (k_count_we_i) k_reg = k_count_i;
      pending_o <= expected_ranks.size();
    end
  end

endmodule

// ----- tb/sv/tb_top_k_select_core.sv -----
// Testbench top for the top-k selector: clock, reset, score stimulus, result back-pressure, verdict.
module tb_top_k_select_core;
  import tks_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            k_count_we_i;
  logic [CfgW-1:0] k_count_i;

  tks_in_if  in_ch ();
  tks_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned vector_count;
  int unsigned result_count;
  logic        sat_seen;

  int unsigned items_sent = 0;
  int unsigned k_writes = 0;
  bit          src_idle_en = 1'b0;
  bit          snk_idle_en = 1'b0;
  int unsigned hold_seq = 0;

  top_k_select_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_count_we_i (k_count_we_i),
    .k_count_i    (k_count_i),
    .in_i         (in_ch),
    .out_o        (out_ch)
  );

  tb_tks_rank_check rank_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .k_count_we_i   (k_count_we_i),
    .k_count_i      (k_count_i),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .vector_count_o (vector_count),
    .result_count_o (result_count),
    .sat_seen_o     (sat_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drive ready: random stalls, a clean stretch, and a long hold-off on request
  initial begin : result_ready
    int unsigned hold_left;
    int unsigned hold_taken;

    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_taken) begin
        hold_taken = hold_seq;
        hold_left  = 90;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (snk_idle_en) begin
        out_ch.ready <= ($urandom_range(99) >= 33);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one score beat, with an optional random gap, and hold until taken
  task automatic send_score(input logic signed [ScoreW-1:0] score, input logic is_last);
    if (src_idle_en && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.score     <= score;
    in_ch.last_item <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every owed result beat has drained
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [CfgW-1:0] value);
    wait_idle();
    k_count_we_i <= 1'b1;
    k_count_i    <= value;
    @(posedge clk_i);
    k_count_we_i <= 1'b0;
    k_writes++;
  endtask

  initial begin : stimulus
    int unsigned              stop_at;
    int unsigned              vec_no;
    int unsigned              len;
    logic signed [ScoreW-1:0] score;

    rst_ni          <= 1'b0;
    k_count_we_i    <= 1'b0;
    k_count_i       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.score     <= '0;
    in_ch.last_item <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short vector under the reset k, with both score extremes
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(32'sh8000_0000, 1'b0);
    send_score(32'sh0000_0000, 1'b1);
    // Ties: equal scores keep arrival order
    send_score(5, 1'b0);
    send_score(5, 1'b0);
    send_score(7, 1'b0);
    send_score(5, 1'b0);
    send_score(7, 1'b0);
    send_score(-1, 1'b0);
    send_score(9, 1'b0);
    send_score(5, 1'b1);
    // One-score vector
    send_score(-3, 1'b1);
    // Zero k reports one rank
    write_k(4'd0);
    send_score(2, 1'b0);
    send_score(8, 1'b0);
    send_score(8, 1'b1);
    // k above the list depth; overflow the list with ties, then a new best
    write_k(4'd15);
    for (int i = 0; i < 8; i++) send_score(4, 1'b0);
    send_score(10, 1'b1);
    // Change k in the middle of a vector
    write_k(4'd8);
    send_score(-7, 1'b0);
    send_score(3, 1'b0);
    send_score(-2, 1'b0);
    write_k(4'd2);
    send_score(6, 1'b0);
    send_score(1, 1'b1);

    // Random vectors: a clean stretch first, then idling on both sides
    stop_at = items_sent + 130;
    vec_no  = 0;
    while (items_sent < stop_at) begin
      if (vec_no == 6) begin
        src_idle_en = 1'b1;
        snk_idle_en <= 1'b1;
      end
      if (vec_no % 5 == 4) write_k(4'($urandom_range(15)));
      // Stall results for a long stretch while vectors keep coming
      if (vec_no == 10) hold_seq <= hold_seq + 1;
      if (vec_no == 17) wait_idle();
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < int'(len); i++) begin
        case ($urandom_range(9))
          0:       score = 32'sh7FFF_FFFF;
          1:       score = 32'sh8000_0000;
          2, 3:    score = $signed($urandom_range(6)) - 3;
          default: score = $urandom();
        endcase
        send_score(score, i == int'(len) - 1);
      end
      vec_no++;
    end

    // Drain every owed result, then keep the clock running to catch strays
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d score beats in %0d vectors, %0d ranked results, %0d k writes.",
             items_sent, vector_count, result_count, k_writes);
    $display("Saturated position reported: %0d; mismatches: %0d.", sat_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d result beats still owed.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
src/tks_pkg.sv
src/tks_in_if.sv
src/tks_out_if.sv
src/tks_cell.sv
src/top_k_select_core.sv
tb/sv/tb_tks_rank_check.sv
tb/sv/tb_top_k_select_core.sv
